@@ hw/rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    typedef enum logic [1:0] {
        KIND_UNIT      = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_REJECTED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       result_kind;
        logic        run_last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       result_kind;
    } unit_t;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]                  count;
        unit_t [MAX_RESULTS-1:0]     slot;
    } bundle_t;

    localparam logic [7:0]  ASCII_MAX     = 8'h7F;
    localparam logic [7:0]  CONT_MAX      = 8'hBF;
    localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
    localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
    localparam logic [7:0]  LEAD4_MAX     = 8'hF7;
    localparam logic [20:0] SURR_LO       = 21'h00D800;
    localparam logic [20:0] SURR_HI       = 21'h00DFFF;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
    localparam logic [19:0] SUPP_BASE     = 20'h10000;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
    localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;

endpackage

@@ hw/rtl/u8u16_decode.sv @@
// Decode state and single-pass conversion of one byte into up to three results.
module u8u16_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  u8u16_pkg::in_item_t item,
    input  logic                advance,
    output u8u16_pkg::bundle_t  bundle
);
    import u8u16_pkg::*;

    logic [20:0] acc_reg,  acc_next;
    logic [1:0]  pend_reg, pend_next;
    logic        disc_reg, disc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= '0;
            disc_reg <= 1'b0;
        end else if (advance) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            disc_reg <= disc_next;
        end
    end

    always_comb begin
        logic [7:0]  ch;
        logic        last;
        logic        done;
        logic        early;
        kind_t       early_kind;
        logic [20:0] cp;
        logic [19:0] v;
        logic [1:0]  n;

        ch         = item.byte_value;
        last       = item.string_end;
        done       = 1'b0;
        early      = 1'b0;
        early_kind = KIND_MALFORMED;
        cp         = '0;
        v          = '0;
        n          = '0;
        bundle     = '0;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        disc_next  = disc_reg;

        if (disc_reg) begin
            done = 1'b1;
            if (last) begin
                disc_next = 1'b0;
                acc_next  = '0;
                pend_next = '0;
            end
        end else if (pend_reg == 2'd0) begin
            if (ch <= ASCII_MAX) begin
                bundle.slot[n] = '{code_unit: {8'h00, ch}, result_kind: KIND_UNIT};
                n = n + 2'd1;
            end else if (ch <= CONT_MAX) begin
                early      = 1'b1;
                early_kind = KIND_REJECTED;
            end else if (ch <= LEAD2_MAX) begin
                acc_next  = {16'h0000, ch[4:0]};
                pend_next = 2'd1;
            end else if (ch <= LEAD3_MAX) begin
                acc_next  = {17'h00000, ch[3:0]};
                pend_next = 2'd2;
            end else if (ch <= LEAD4_MAX) begin
                acc_next  = {18'h00000, ch[2:0]};
                pend_next = 2'd3;
            end else begin
                early = 1'b1;
            end
        end else begin
            if (ch[7:6] != 2'b10) begin
                early = 1'b1;
            end else begin
                cp        = {acc_reg[14:0], ch[5:0]};
                acc_next  = cp;
                pend_next = pend_reg - 2'd1;
                if (pend_next == 2'd0) begin
                    if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
                        early = 1'b1;
                    end else if (cp <= BMP_MAX) begin
                        bundle.slot[n] = '{code_unit: cp[15:0], result_kind: KIND_UNIT};
                        n = n + 2'd1;
                    end else begin
                        v = cp[19:0] - SUPP_BASE;
                        bundle.slot[n] = '{code_unit: HI_SURR_BASE + {6'b000000, v[19:10]},
                                           result_kind: KIND_UNIT};
                        n = n + 2'd1;
                        bundle.slot[n] = '{code_unit: LO_SURR_BASE + {6'b000000, v[9:0]},
                                           result_kind: KIND_UNIT};
                        n = n + 2'd1;
                    end
                    acc_next = '0;
                end
            end
        end

        if (early) begin
            bundle.slot[n] = '{code_unit: 16'h0000, result_kind: early_kind};
            n         = n + 2'd1;
            acc_next  = '0;
            pend_next = '0;
            disc_next = !last;
            done      = 1'b1;
        end

        if (!done && last) begin
            bundle.slot[n] = '{code_unit: 16'h0000,
                               result_kind: (pend_next != 2'd0) ? KIND_MALFORMED : KIND_END};
            n         = n + 2'd1;
            acc_next  = '0;
            pend_next = '0;
        end

        bundle.count = n;
    end

endmodule

@@ hw/rtl/u8u16_out_buf.sv @@
// Result register holding one byte's results and handing them out one per cycle while m_ready is high.
module u8u16_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  u8u16_pkg::bundle_t   bundle,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8u16_pkg::out_item_t m_item
);
    import u8u16_pkg::*;

    unit_t [MAX_RESULTS-1:0] slot_reg;
    logic  [1:0]             cnt_reg;
    logic                    take;

    assign m_valid = (cnt_reg != 2'd0);
    assign take    = m_valid && m_ready;
    assign free    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    assign m_item.code_unit   = slot_reg[0].code_unit;
    assign m_item.result_kind = slot_reg[0].result_kind;
    assign m_item.run_last    = (cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= bundle.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= bundle.slot;
        end else if (take) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

@@ hw/rtl/utf8_to_utf16_transcoder_unit.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, result buffer.
//
// Takes one UTF-8 byte per cycle, when not stalled, through a registered input stage
// and converts it in a single pass into zero to three results (a code unit, a
// surrogate pair, and/or a string terminator), which leave on the m_ channel one
// per cycle while m_ready is high, with run_last set on the final result of each
// byte. A byte with results holds the result buffer until its results are taken,
// so throughput is one byte per cycle while m_ready is high and each byte yields at
// most one result, and a following byte waits behind bytes that complete a
// supplementary code point or carry a code unit together with a string terminator;
// bytes that yield nothing (lead bytes, inner continuation bytes, dropped bytes)
// pass through without using the result buffer. The first result of a byte is
// presented once the byte has passed the input register and the result buffer, and m_ready low stalls the input.
module utf8_to_utf16_transcoder_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  u8u16_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8u16_pkg::out_item_t m_item
);
    import u8u16_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    bundle_t  bundle;
    logic     buf_free;
    logic     xfer;
    logic     load;

    assign xfer    = in_valid_reg && (bundle.count == 2'd0 || buf_free);
    assign load    = xfer && (bundle.count != 2'd0);
    assign s_ready = !in_valid_reg || xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (xfer) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    u8u16_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .advance (xfer),
        .bundle  (bundle)
    );

    u8u16_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .bundle  (bundle),
        .free    (buf_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded results not presented");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !xfer |=> in_valid_reg)
        else $error("stalled input item lost");

    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind != KIND_UNIT |-> m_item.run_last)
        else $error("terminator not last result of its byte");

    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind != KIND_UNIT |-> m_item.code_unit == 16'h0000)
        else $error("terminator carries nonzero code unit");

    a_hi_surr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == KIND_UNIT
            && m_item.code_unit[15:10] == HI_SURR_TAG |-> !m_item.run_last)
        else $error("high surrogate without low surrogate");
`endif

endmodule
